// ===== sv/eau_pkg.sv =====
// Shared types and constants of the 68000 effective-address unit.
// No dependencies; eau_regfile, eau_calc and the top level import this package.
package eau_pkg;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    MODE_DREG    = 3'd0,
    MODE_AREG    = 3'd1,
    MODE_IND     = 3'd2,
    MODE_POSTINC = 3'd3,
    MODE_PREDEC  = 3'd4,
    MODE_DISP    = 3'd5,
    MODE_INDEX   = 3'd6,
    MODE_EXT     = 3'd7
  } mode_t;

  // Register-field codes used together with MODE_EXT.
  typedef enum logic [2:0] {
    EXT_ABS_W  = 3'd0,
    EXT_ABS_L  = 3'd1,
    EXT_PC_D16 = 3'd2,
    EXT_PC_IDX = 3'd3,
    EXT_IMM    = 3'd4
  } ext_mode_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_WORD = 2'd1,
    SIZE_LONG = 2'd2
  } size_t;

  localparam logic [31:0] ADDR24_MASK = 32'h00FF_FFFF;
  localparam logic [2:0]  STACK_REG   = 3'd7;

  // One register-file write: a write item or an address-register update.
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } wb_t;

endpackage

// ===== sv/eau_regfile.sv =====
// Sixteen-entry register file (D0-D7, A0-A7) with two registered read ports.
// Depends on eau_pkg for the write-back struct.
module eau_regfile
  import eau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr_a,
  input  logic [3:0]  rd_addr_b,
  input  wb_t         wb,
  output logic [31:0] rd_data_a,
  output logic [31:0] rd_data_b
);

  logic [31:0] mem [16];
  logic [15:0] written;

  always_ff @(posedge clk) begin
    if (wb.en) begin
      mem[wb.addr] <= wb.data;
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wb.en) begin
      written[wb.addr] <= 1'b1;
    end
  end

  // A write landing on the same edge is forwarded to the read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wb.en && wb.addr == rd_addr_a) begin
        rd_data_a <= wb.data;
      end else begin
        rd_data_a <= written[rd_addr_a] ? mem[rd_addr_a] : '0;
      end
      if (wb.en && wb.addr == rd_addr_b) begin
        rd_data_b <= wb.data;
      end else begin
        rd_data_b <= written[rd_addr_b] ? mem[rd_addr_b] : '0;
      end
    end
  end

endmodule

// ===== sv/eau_calc.sv =====
// Combinational effective-address decode for one item held in the work stage.
// Depends on eau_pkg for mode codes, size codes and the write-back struct.
module eau_calc
  import eau_pkg::*;
(
  input  logic        op,
  input  logic [3:0]  reg_select,
  input  logic [31:0] write_value,
  input  logic [2:0]  mode,
  input  logic [2:0]  reg_req,
  input  logic [1:0]  size_code,
  input  logic [15:0] ext_first,
  input  logic [15:0] ext_second,
  input  logic [31:0] ext_addr,
  input  logic [31:0] rd_base,
  input  logic [31:0] rd_index,
  output logic [31:0] ea,
  output logic [1:0]  ext_used,
  output logic        ok,
  output wb_t         wb
);

  logic [31:0] size_mask;
  logic [2:0]  step;
  logic [31:0] disp16;
  logic [31:0] disp8;
  logic [31:0] index_val;
  logic [31:0] index_term;
  logic [31:0] an_inc;
  logic [31:0] an_dec;
  logic [3:0]  an_addr;

  always_comb begin
    unique case (size_code)
      SIZE_BYTE: begin
        size_mask = 32'h0000_00FF;
        step      = (reg_req == STACK_REG) ? 3'd2 : 3'd1;
      end
      SIZE_WORD: begin
        size_mask = 32'h0000_FFFF;
        step      = 3'd2;
      end
      default: begin
        size_mask = 32'hFFFF_FFFF;
        step      = 3'd4;
      end
    endcase
  end

  assign disp16     = {{16{ext_first[15]}}, ext_first};
  assign disp8      = {{24{ext_first[7]}}, ext_first[7:0]};
  assign index_val  = ext_first[11] ? rd_index : {{16{rd_index[15]}}, rd_index[15:0]};
  assign index_term = disp8 + index_val;
  assign an_inc     = rd_base + {29'd0, step};
  assign an_dec     = rd_base - {29'd0, step};
  assign an_addr    = {1'b1, reg_req};

  always_comb begin
    ea       = '0;
    ext_used = 2'd0;
    ok       = 1'b1;
    wb       = '0;
    if (op == OP_WRITE) begin
      wb = '{en: 1'b1, addr: reg_select, data: write_value};
    end else begin
      unique case (mode)
        MODE_DREG, MODE_AREG: ea = rd_base & size_mask;
        MODE_IND:             ea = rd_base & ADDR24_MASK;
        MODE_POSTINC: begin
          ea = rd_base & ADDR24_MASK;
          wb = '{en: 1'b1, addr: an_addr, data: an_inc};
        end
        MODE_PREDEC: begin
          ea = an_dec & ADDR24_MASK;
          wb = '{en: 1'b1, addr: an_addr, data: an_dec};
        end
        MODE_DISP: begin
          ea       = rd_base + disp16;
          ext_used = 2'd1;
        end
        MODE_INDEX: begin
          ea       = rd_base + index_term;
          ext_used = 2'd1;
        end
        default: begin
          unique case (reg_req)
            EXT_ABS_W: begin
              ea       = disp16;
              ext_used = 2'd1;
            end
            EXT_ABS_L: begin
              ea       = {ext_first, ext_second};
              ext_used = 2'd2;
            end
            EXT_PC_D16: begin
              ea       = ext_addr + disp16;
              ext_used = 2'd1;
            end
            EXT_PC_IDX: begin
              ea       = ext_addr + index_term;
              ext_used = 2'd1;
            end
            EXT_IMM: begin
              ea       = ext_addr;
              ext_used = (size_code == SIZE_BYTE || size_code == SIZE_WORD) ? 2'd1 : 2'd2;
            end
            default: ok = 1'b0;
          endcase
        end
      endcase
    end
  end

endmodule

// ===== sv/m68k_effective_address_unit.sv =====
// Top level of the 68000 effective-address unit: input stage, register file,
// address decode and result register. Depends on eau_pkg, eau_regfile, eau_calc.
//
// The unit keeps D0-D7 and A0-A7 and turns one word per cycle into an
// effective address, the count of extension words it consumed and a flag
// that is low for the unused patterns 7/5 to 7/7. A word with op = write
// loads one register and returns ea 0, ext_used 0, ok 1. On acceptance
// of a word the register file is read (base register and index register
// from bits 15-12 of ext_first) into the work stage, and when the work
// stage advances the decoded result goes into the output register. The
// register file has one write port shared by register loads and by the
// postincrement and predecrement updates; a write is forwarded to a read on
// the same edge, so back-to-back words that touch the same register see
// each other's updates in order. Sustained rate is one word per cycle as
// long as out_stall stays low; a stalled result holds the work stage, and
// in_stall rises only when both the work stage and the output register are
// full. The absolute long mode takes ext_first as the high half. instr_addr
// is carried on the port for completeness but no mode uses it: PC-relative
// modes use ext_addr as their base. After reset all sixteen registers read
// as zero; no clearing pass is needed.
module m68k_effective_address_unit
  import eau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [3:0]  reg_select,
  input  logic [31:0] write_value,
  input  logic [2:0]  mode,
  input  logic [2:0]  reg_req,
  input  logic [1:0]  size_code,
  input  logic [15:0] ext_first,
  input  logic [15:0] ext_second,
  input  logic [31:0] instr_addr,
  input  logic [31:0] ext_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] ea,
  output logic [1:0]  ext_used,
  output logic        ok
);

  // Work stage: the accepted word, waiting for its register reads.
  logic        s1_valid;
  logic        s1_op;
  logic [3:0]  s1_sel;
  logic [31:0] s1_wval;
  logic [2:0]  s1_mode;
  logic [2:0]  s1_rn;
  logic [1:0]  s1_size;
  logic [15:0] s1_e1;
  logic [15:0] s1_e2;
  logic [31:0] s1_xaddr;

  logic        in_accept;
  logic        s1_move;
  logic [3:0]  rd_addr_a;
  logic [31:0] rd_base;
  logic [31:0] rd_index;
  logic [31:0] calc_ea;
  logic [1:0]  calc_used;
  logic        calc_ok;
  wb_t         calc_wb;
  wb_t         wb;

  // The work stage advances when the output register is empty or draining.
  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_move;
  assign in_accept = in_valid && !in_stall;

  // Data-register direct reads Dn; every other mode reads An on port A.
  assign rd_addr_a = {mode != MODE_DREG, reg_req};

  // A register write takes effect only when its word leaves the work stage.
  always_comb begin
    wb    = calc_wb;
    wb.en = calc_wb.en && s1_move;
  end

  eau_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (ext_first[15:12]),
    .wb        (wb),
    .rd_data_a (rd_base),
    .rd_data_b (rd_index)
  );

  eau_calc u_calc (
    .op          (s1_op),
    .reg_select  (s1_sel),
    .write_value (s1_wval),
    .mode        (s1_mode),
    .reg_req     (s1_rn),
    .size_code   (s1_size),
    .ext_first   (s1_e1),
    .ext_second  (s1_e2),
    .ext_addr    (s1_xaddr),
    .rd_base     (rd_base),
    .rd_index    (rd_index),
    .ea          (calc_ea),
    .ext_used    (calc_used),
    .ok          (calc_ok),
    .wb          (calc_wb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op    <= op;
      s1_sel   <= reg_select;
      s1_wval  <= write_value;
      s1_mode  <= mode;
      s1_rn    <= reg_req;
      s1_size  <= size_code;
      s1_e1    <= ext_first;
      s1_e2    <= ext_second;
      s1_xaddr <= ext_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ea       <= calc_ea;
      ext_used <= calc_used;
      ok       <= calc_ok;
    end
  end

endmodule

// ===== sv/eau_check.sv =====
// Port-level checker for the effective-address unit, bound to the top level.
// Does not import eau_pkg; its ports are plain logic.
module eau_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] ea,
  input logic [1:0]  ext_used,
  input logic        ok
);

  // No result appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // An unused pattern reports nothing else.
  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> ea == 32'd0 && ext_used == 2'd0)
    else $error("invalid pattern carries an address or extension count");

  // At most two extension words per operand.
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ext_used != 2'd3)
    else $error("extension word count out of range");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ea) && $stable(ext_used) && $stable(ok))
    else $error("stalled result changed");

  // With the output free, the input side is never stalled.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

endmodule

bind m68k_effective_address_unit eau_check u_eau_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .ea        (ea),
  .ext_used  (ext_used),
  .ok        (ok)
);
